/* rtl/floppy_chs_command_former_defines.svh */
// assertion macros for the floppy chs command former
`ifndef FLOPPY_CHS_COMMAND_FORMER_DEFINES_SVH
`define FLOPPY_CHS_COMMAND_FORMER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, reset masks the check
`define FCF_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("fcf same-cycle check failed");

// next-cycle implication, reset masks the check
`define FCF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("fcf next-cycle check failed");

`else

`define FCF_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define FCF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

/* rtl/fcf_pkg.sv */
package fcf_pkg;

  // byte offset bits that take part in the conversion
  localparam int OffsetBits = 24;
  localparam int OffUsed    = (OffsetBits < 24) ? OffsetBits : 24;
  localparam logic [23:0] OffMask = 24'((33'(1) << OffUsed) - 33'(1));

  // logical sector numbers, dividend of the sector divider
  localparam int QuoW          = 18;
  localparam int SptW          = 6;
  localparam int StepsPerStage = 6;
  localparam int DivStages     = (QuoW + StepsPerStage - 1) / StepsPerStage;

  localparam int AddrW = 5;

  typedef enum logic [2:0] {
    RegSizeCode  = 3'd0,
    RegSpt       = 3'd1,
    RegHeadCount = 3'd2,
    RegSteps     = 3'd3,
    RegGapLength = 3'd4
  } reg_idx_t;

  localparam logic [1:0] FuncRead  = 2'd0;
  localparam logic [1:0] FuncWrite = 2'd1;

  localparam logic [7:0] CmdRead  = 8'h66;
  localparam logic [7:0] CmdWrite = 8'h45;
  localparam logic [7:0] CmdMulti = 8'h80;
  localparam logic [7:0] CmdSeek  = 8'h0f;

  typedef struct packed {
    logic [1:0]      size_code;
    logic [SptW-1:0] spt;
    logic [1:0]      head_count;
    logic [1:0]      steps;
    logic [7:0]      gap;
  } cfg_t;

  // one divider lane: partial remainder and dividend shifting into quotient
  typedef struct packed {
    logic [SptW-1:0] rem;
    logic [QuoW-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  drive;
    logic [23:0] len;
    lane_t       first;
    lane_t       last;
  } item_t;

  typedef struct packed {
    logic [7:0]  cylinder;
    logic        head;
    logic [5:0]  sector;
    logic [7:0]  track;
    logic [23:0] clipped_length;
    logic [7:0]  command_byte;
    logic [2:0]  unit_byte;
    logic        range_error;
  } result_t;

endpackage

/* rtl/floppy_chs_command_former.sv */
// Floppy CHS command former. Each beat on the input carries a request (read,
// write or seek), a drive, a byte offset and a length; each beat on the output
// carries cylinder, head, 1-based sector, physical track, the length clipped
// at the cylinder boundary, the controller command byte, the unit byte and a
// range flag for cylinders above 255. Geometry comes from the APB registers
// (size code, sectors per track, heads, steps per cylinder, gap length at byte
// addresses 0, 4, 8, 12, 16); write them only while the block is empty. One
// request is taken every cycle while the input is not stalled, and its result
// reaches the output through five register stages:
// one entry stage that forms the start and end sector numbers, three stages of
// a restoring divider by sectors per track (six quotient bits per stage, start
// and end lanes side by side), and one finishing stage that is the output
// register. Empty stages fill in behind a stalled output, so the input stalls
// only when every stage holds a beat.
`include "floppy_chs_command_former_defines.svh"

module floppy_chs_command_former (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_func,
  input  logic [1:0]                in_drive,
  input  logic [23:0]               in_byte_offset,
  input  logic [23:0]               in_length,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_cylinder,
  output logic                      out_head,
  output logic [5:0]                out_sector,
  output logic [7:0]                out_track,
  output logic [23:0]               out_clipped_length,
  output logic [7:0]                out_command_byte,
  output logic [2:0]                out_unit_byte,
  output logic                      out_range_error,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fcf_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // entry stage, divider stages, output stage
  localparam int NStg = fcf_pkg::DivStages + 2;

  fcf_pkg::cfg_t            cfg;
  logic [fcf_pkg::SptW-1:0] spt_eff;

  fcf_pkg::item_t   pipe_r [fcf_pkg::DivStages+1];
  fcf_pkg::item_t   div_out [fcf_pkg::DivStages];
  fcf_pkg::result_t res_r;
  fcf_pkg::result_t res_nxt;
  logic [NStg-1:0]  v_r;
  logic [NStg-1:0]  en;

  // entry stage datapath
  logic [23:0]      off;
  logic [24:0]      end_pos;
  logic [3:0]       shamt;
  fcf_pkg::item_t   entry;

  fcf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // zero sectors per track behaves as one
  assign spt_eff = (cfg.spt == '0) ? fcf_pkg::SptW'(1) : cfg.spt;

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    en[NStg-1] = !v_r[NStg-1] || !out_stall;
    for (int i = NStg - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  // bytes per sector is 128 << size code, so sector number is a plain shift
  assign off     = in_byte_offset & fcf_pkg::OffMask;
  assign end_pos = {1'b0, off} + {1'b0, in_length};
  assign shamt   = 4'd7 + {2'd0, cfg.size_code};

  always_comb begin
    entry.func      = in_func;
    entry.drive     = in_drive;
    entry.len       = in_length;
    entry.first.rem = '0;
    entry.first.quo = fcf_pkg::QuoW'({1'b0, off} >> shamt);
    entry.last.rem  = '0;
    entry.last.quo  = fcf_pkg::QuoW'(end_pos >> shamt);
  end

  // divider stages, each retiring six quotient bits on both lanes
  for (genvar g = 0; g < fcf_pkg::DivStages; g++) begin : g_div
    fcf_div_stage u_div (
      .item_in  (pipe_r[g]),
      .divisor  (spt_eff),
      .item_out (div_out[g])
    );
  end

  // cylinder, head, track, clip and command bytes from the full quotients
  fcf_finish u_finish (
    .item    (pipe_r[fcf_pkg::DivStages]),
    .cfg     (cfg),
    .spt_eff (spt_eff),
    .res     (res_nxt)
  );

  // valid bits travel with the beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NStg; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pipe_r[0] <= entry;
    end
    for (int i = 0; i < fcf_pkg::DivStages; i++) begin
      if (en[i+1]) begin
        pipe_r[i+1] <= div_out[i];
      end
    end
    if (en[NStg-1]) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = v_r[NStg-1];
  assign out_cylinder       = res_r.cylinder;
  assign out_head           = res_r.head;
  assign out_sector         = res_r.sector;
  assign out_track          = res_r.track;
  assign out_clipped_length = res_r.clipped_length;
  assign out_command_byte   = res_r.command_byte;
  assign out_unit_byte      = res_r.unit_byte;
  assign out_range_error    = res_r.range_error;

  // an out-of-range cylinder saturates the cylinder; the track saturates too,
  // or stays zero when steps per cylinder is zero
  `FCF_ASSERT_IMPL(a_range_sat, clk, rst_n, out_valid && out_range_error,
                   out_cylinder == 8'hff && (out_track == 8'hff || out_track == 8'h00))
  // a second head only shows up on two-head media, and sectors count from one
  `FCF_ASSERT_IMPL(a_head_geom, clk, rst_n, out_valid,
                   (!out_head || cfg.head_count[1]) && out_sector != 6'd0 &&
                   out_unit_byte[2] == out_head)
  // the input stalls only when every stage is full and the output is held
  `FCF_ASSERT_IMPL(a_stall_full, clk, rst_n, in_stall, (&v_r) && out_stall)

endmodule

/* rtl/fcf_cfg.sv */
module fcf_cfg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [fcf_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output fcf_pkg::cfg_t            cfg
);

  fcf_pkg::cfg_t     cfg_r;
  fcf_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = fcf_pkg::reg_idx_t'(paddr[fcf_pkg::AddrW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_code  <= 2'd2;
      cfg_r.spt        <= 6'd18;
      cfg_r.head_count <= 2'd2;
      cfg_r.steps      <= 2'd1;
      cfg_r.gap        <= 8'd27;
    end else if (wr) begin
      case (idx)
        fcf_pkg::RegSizeCode:  cfg_r.size_code  <= pwdata[1:0];
        fcf_pkg::RegSpt:       cfg_r.spt        <= pwdata[5:0];
        fcf_pkg::RegHeadCount: cfg_r.head_count <= pwdata[1:0];
        fcf_pkg::RegSteps:     cfg_r.steps      <= pwdata[1:0];
        fcf_pkg::RegGapLength: cfg_r.gap        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fcf_pkg::RegSizeCode:  prdata = {30'd0, cfg_r.size_code};
      fcf_pkg::RegSpt:       prdata = {26'd0, cfg_r.spt};
      fcf_pkg::RegHeadCount: prdata = {30'd0, cfg_r.head_count};
      fcf_pkg::RegSteps:     prdata = {30'd0, cfg_r.steps};
      fcf_pkg::RegGapLength: prdata = {24'd0, cfg_r.gap};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/fcf_div_stage.sv */
module fcf_div_stage (
  input  fcf_pkg::item_t              item_in,
  input  logic [fcf_pkg::SptW-1:0]    divisor,
  output fcf_pkg::item_t              item_out
);

  // one restoring step: next dividend bit into the remainder, one quotient bit out
  function automatic fcf_pkg::lane_t div_step(fcf_pkg::lane_t l,
                                              logic [fcf_pkg::SptW-1:0] d);
    fcf_pkg::lane_t          r;
    logic [fcf_pkg::SptW:0]  t;
    t     = {l.rem, l.quo[fcf_pkg::QuoW-1]};
    r.quo = {l.quo[fcf_pkg::QuoW-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem    = fcf_pkg::SptW'(t - {1'b0, d});
      r.quo[0] = 1'b1;
    end else begin
      r.rem = t[fcf_pkg::SptW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    fcf_pkg::item_t it;
    it = item_in;
    for (int s = 0; s < fcf_pkg::StepsPerStage; s++) begin
      it.first = div_step(it.first, divisor);
      it.last  = div_step(it.last, divisor);
    end
    item_out = it;
  end

endmodule

/* rtl/fcf_finish.sv */
module fcf_finish (
  input  fcf_pkg::item_t           item,
  input  fcf_pkg::cfg_t            cfg,
  input  logic [fcf_pkg::SptW-1:0] spt_eff,
  output fcf_pkg::result_t         res
);

  logic                     heads2;
  logic [fcf_pkg::QuoW-1:0] cyl, cyl_e;
  logic                     head, head_e;
  logic [fcf_pkg::SptW:0]   pos_e;
  logic [16:0]              cut;
  logic [19:0]              prod;
  logic                     range;
  logic [23:0]              clipped;
  logic [7:0]               multi;

  assign heads2 = cfg.head_count[1];

  // quotient is sector / spt; one more halving when two heads
  assign cyl    = heads2 ? {1'b0, item.first.quo[fcf_pkg::QuoW-1:1]} : item.first.quo;
  assign head   = heads2 & item.first.quo[0];
  assign cyl_e  = heads2 ? {1'b0, item.last.quo[fcf_pkg::QuoW-1:1]} : item.last.quo;
  assign head_e = heads2 & item.last.quo[0];

  // end position inside its cylinder, in bytes
  assign pos_e = {1'b0, item.last.rem} + (head_e ? {1'b0, spt_eff} : 7'd0);
  assign cut   = 17'({pos_e, 7'd0}) << cfg.size_code;

  always_comb begin
    clipped = item.len;
    if (cyl_e != cyl) begin
      clipped = ({7'd0, cut} <= item.len) ? item.len - {7'd0, cut} : 24'd0;
    end
  end

  assign range = |cyl[fcf_pkg::QuoW-1:8];
  assign prod  = {2'd0, cyl} * {18'd0, cfg.steps};
  assign multi = heads2 ? fcf_pkg::CmdMulti : 8'd0;

  always_comb begin
    res.cylinder       = range ? 8'hff : cyl[7:0];
    res.head           = head;
    res.sector         = item.first.rem + 6'd1;
    res.track          = (|prod[19:8]) ? 8'hff : prod[7:0];
    res.clipped_length = clipped;
    res.unit_byte      = {head, item.drive};
    res.range_error    = range;
    case (item.func)
      fcf_pkg::FuncRead:  res.command_byte = fcf_pkg::CmdRead | multi;
      fcf_pkg::FuncWrite: res.command_byte = fcf_pkg::CmdWrite | multi;
      default:            res.command_byte = fcf_pkg::CmdSeek;
    endcase
  end

endmodule
